// File: hw/rtl/pfdc_pkg.sv
// shared types and constants for the packet fifo with duplicate filter
package pfdc_pkg;

	// operation codes carried on func
	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_FWD   = 2'd1,
		FUNC_COUNT = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// per-cycle command broadcast to every storage cell
	typedef struct packed {
		logic shift;
		logic wr_en;
	} cell_ctrl_t;

	localparam int          LIMIT_BITS  = 7;
	localparam logic [6:0]  LIMIT_RESET = 7'd64;
	localparam int          COUNT_BITS  = 7;
	localparam logic [6:0]  COUNT_MAX   = 7'd127;

endpackage

// File: hw/rtl/packet_fifo_dedup_count.sv
// top level of the bounded packet fifo with duplicate filter and range count
//
// Packets (source, destination, timestamp) sit in a row of DEPTH cells, the
// oldest in cell 0; a pop shifts every cell one place toward cell 0 and an add
// writes the cell just past the last live one. An operation is taken when start
// is high and busy is low. Add and count run a scan in which every cell
// compares itself with the request and hands a running duplicate flag and match
// tally to its neighbor, one cell per clock, in the scan state; the result beat
// is registered in the finish state and appears with done, and busy stays
// high until then. Forward and the unused code skip the scan and go straight to
// the finish state. done is high for exactly one cycle and the result cannot be
// held off, so capture it then; a new operation may be started in that same
// cycle. The user must write memory_limit through cfg_valid/cfg_data (always
// ready) only while the block is idle, which the block does not enforce; 0 acts
// as 1 and values above DEPTH act as DEPTH. No clearing pass follows reset.
module packet_fifo_dedup_count #(
	parameter int DEPTH      = 64,
	parameter int ID_BITS    = 16,
	parameter int STAMP_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// operation channel
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic [ID_BITS-1:0]              src_id,
	input  logic [ID_BITS-1:0]              dst_id,
	input  logic [STAMP_BITS-1:0]           stamp,
	input  logic [STAMP_BITS-1:0]           start_time,
	input  logic [STAMP_BITS-1:0]           end_time,
	// result channel
	output logic                            done,
	output logic                            ok,
	output logic [ID_BITS-1:0]              out_src,
	output logic [ID_BITS-1:0]              out_dst,
	output logic [STAMP_BITS-1:0]           out_stamp,
	output logic [pfdc_pkg::COUNT_BITS-1:0] match_count,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfdc_pkg::LIMIT_BITS-1:0] cfg_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);
	// common width for comparing the limit register against occupancy
	localparam int LIM_W = (CNT_W > pfdc_pkg::LIMIT_BITS) ? CNT_W : pfdc_pkg::LIMIT_BITS;
	// common width for saturating the tally to the result field
	localparam int SAT_W = (CNT_W > pfdc_pkg::COUNT_BITS) ? CNT_W : pfdc_pkg::COUNT_BITS;

	// control state
	pfdc_pkg::state_t             state_q, state_d;
	logic [IDX_W-1:0]             scan_q, scan_d;
	logic [CNT_W-1:0]             occ_q, occ_d;
	logic [pfdc_pkg::LIMIT_BITS-1:0] limit_q;

	// request held for the whole operation
	pfdc_pkg::func_t              func_q;
	logic [ID_BITS-1:0]           req_src_q;
	logic [ID_BITS-1:0]           req_dst_q;
	logic [STAMP_BITS-1:0]        req_stamp_q;
	logic [STAMP_BITS-1:0]        req_lo_q;
	logic [STAMP_BITS-1:0]        req_hi_q;

	// result beat registers
	logic                         done_q;
	logic                         ok_q, ok_d;
	logic [ID_BITS-1:0]           out_src_q, out_src_d;
	logic [ID_BITS-1:0]           out_dst_q, out_dst_d;
	logic [STAMP_BITS-1:0]        out_stamp_q, out_stamp_d;
	logic [pfdc_pkg::COUNT_BITS-1:0] match_q, match_d;

	// cell chain wiring
	pfdc_pkg::cell_ctrl_t         ctrl;
	logic [IDX_W-1:0]             wr_idx;
	logic [ID_BITS-1:0]           slot_src   [DEPTH];
	logic [ID_BITS-1:0]           slot_dst   [DEPTH];
	logic [STAMP_BITS-1:0]        slot_stamp [DEPTH];
	logic [CNT_W-1:0]             cnt_chain  [DEPTH+1];
	logic                         dup_chain  [DEPTH+1];

	logic                         accept;
	logic [LIM_W-1:0]             limit_ext;
	logic [LIM_W-1:0]             limit_eff;
	logic [LIM_W-1:0]             occ_ext;
	logic                         evict;
	logic [SAT_W-1:0]             tally_ext;

	assign accept    = start && !busy;
	assign busy      = (state_q != pfdc_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	// effective limit: zero acts as one, anything past the row acts as its length
	assign limit_ext = LIM_W'(limit_q);
	assign occ_ext   = LIM_W'(occ_q);
	always_comb begin
		if (limit_q == '0) begin
			limit_eff = LIM_W'(1);
		end else if (limit_ext > LIM_W'(DEPTH)) begin
			limit_eff = LIM_W'(DEPTH);
		end else begin
			limit_eff = limit_ext;
		end
	end

	assign evict     = (occ_ext >= limit_eff) && (occ_q != '0);
	assign tally_ext = SAT_W'(cnt_chain[DEPTH]);

	// the chain: cell 0 holds the oldest packet, tallies run from cell 0 upward
	assign cnt_chain[0] = '0;
	assign dup_chain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		localparam int NXT = (i == DEPTH-1) ? i : i + 1;
		pfdc_cell #(
			.DEPTH      (DEPTH),
			.ID_BITS    (ID_BITS),
			.STAMP_BITS (STAMP_BITS),
			.IDX        (i)
		) u_slot (
			.clk       (clk),
			.ctrl      (ctrl),
			.wr_idx    (wr_idx),
			.occ       (occ_q),
			.req_src   (req_src_q),
			.req_dst   (req_dst_q),
			.req_stamp (req_stamp_q),
			.req_lo    (req_lo_q),
			.req_hi    (req_hi_q),
			.nxt_src   (slot_src[NXT]),
			.nxt_dst   (slot_dst[NXT]),
			.nxt_stamp (slot_stamp[NXT]),
			.src       (slot_src[i]),
			.dst       (slot_dst[i]),
			.stamp     (slot_stamp[i]),
			.cnt_in    (cnt_chain[i]),
			.dup_in    (dup_chain[i]),
			.cnt_out   (cnt_chain[i+1]),
			.dup_out   (dup_chain[i+1])
		);
	end

	// sequencer: next state, cell commands and the result beat
	always_comb begin
		state_d     = state_q;
		scan_d      = scan_q;
		occ_d       = occ_q;
		ctrl        = '0;
		wr_idx      = '0;
		ok_d        = 1'b0;
		out_src_d   = '0;
		out_dst_d   = '0;
		out_stamp_d = '0;
		match_d     = '0;

		unique case (state_q)
			pfdc_pkg::ST_IDLE: begin
				scan_d = '0;
				if (accept) begin
					// add and count need the full tally; others finish at once
					if ((pfdc_pkg::func_t'(func) == pfdc_pkg::FUNC_ADD) ||
					    (pfdc_pkg::func_t'(func) == pfdc_pkg::FUNC_COUNT)) begin
						state_d = pfdc_pkg::ST_SCAN;
					end else begin
						state_d = pfdc_pkg::ST_FINISH;
					end
				end
			end
			pfdc_pkg::ST_SCAN: begin
				// at the end of the scan the last cell holds the tally over every cell
				scan_d = scan_q + IDX_W'(1);
				if (scan_q == IDX_W'(DEPTH-1)) begin
					state_d = pfdc_pkg::ST_FINISH;
				end
			end
			pfdc_pkg::ST_FINISH: begin
				state_d = pfdc_pkg::ST_IDLE;
				unique case (func_q)
					pfdc_pkg::FUNC_ADD: begin
						if (!dup_chain[DEPTH]) begin
							ok_d         = 1'b1;
							ctrl.wr_en   = 1'b1;
							ctrl.shift   = evict;
							// with an eviction the new packet lands one place lower
							if (evict) begin
								wr_idx = IDX_W'(occ_q - CNT_W'(1));
							end else begin
								wr_idx = IDX_W'(occ_q);
								occ_d  = occ_q + CNT_W'(1);
							end
						end
					end
					pfdc_pkg::FUNC_FWD: begin
						if (occ_q != '0) begin
							ok_d        = 1'b1;
							out_src_d   = slot_src[0];
							out_dst_d   = slot_dst[0];
							out_stamp_d = slot_stamp[0];
							ctrl.shift  = 1'b1;
							occ_d       = occ_q - CNT_W'(1);
						end
					end
					pfdc_pkg::FUNC_COUNT: begin
						if (tally_ext > SAT_W'(pfdc_pkg::COUNT_MAX)) begin
							match_d = pfdc_pkg::COUNT_MAX;
						end else begin
							match_d = tally_ext[pfdc_pkg::COUNT_BITS-1:0];
						end
					end
					pfdc_pkg::FUNC_NONE: begin
						// unused code: all-zero beat, nothing changes
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = pfdc_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfdc_pkg::ST_IDLE;
			scan_q  <= '0;
			occ_q   <= '0;
			limit_q <= pfdc_pkg::LIMIT_RESET;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			occ_q   <= occ_d;
			done_q  <= (state_q == pfdc_pkg::ST_FINISH);
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
		end
	end

	// request capture and result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= pfdc_pkg::func_t'(func);
			req_src_q   <= src_id;
			req_dst_q   <= dst_id;
			req_stamp_q <= stamp;
			req_lo_q    <= start_time;
			req_hi_q    <= end_time;
		end
		if (state_q == pfdc_pkg::ST_FINISH) begin
			ok_q        <= ok_d;
			out_src_q   <= out_src_d;
			out_dst_q   <= out_dst_d;
			out_stamp_q <= out_stamp_d;
			match_q     <= match_d;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign out_src     = out_src_q;
	assign out_dst     = out_dst_q;
	assign out_stamp   = out_stamp_q;
	assign match_count = match_q;

endmodule

// File: hw/rtl/pfdc_cell.sv
// one storage cell of the packet chain with its compare and running tally
module pfdc_cell #(
	parameter int DEPTH      = 64,
	parameter int ID_BITS    = 16,
	parameter int STAMP_BITS = 32,
	parameter int IDX        = 0
) (
	input  logic                         clk,
	input  pfdc_pkg::cell_ctrl_t         ctrl,
	input  logic [$clog2(DEPTH)-1:0]     wr_idx,
	input  logic [$clog2(DEPTH+1)-1:0]   occ,
	input  logic [ID_BITS-1:0]           req_src,
	input  logic [ID_BITS-1:0]           req_dst,
	input  logic [STAMP_BITS-1:0]        req_stamp,
	input  logic [STAMP_BITS-1:0]        req_lo,
	input  logic [STAMP_BITS-1:0]        req_hi,
	input  logic [ID_BITS-1:0]           nxt_src,
	input  logic [ID_BITS-1:0]           nxt_dst,
	input  logic [STAMP_BITS-1:0]        nxt_stamp,
	output logic [ID_BITS-1:0]           src,
	output logic [ID_BITS-1:0]           dst,
	output logic [STAMP_BITS-1:0]        stamp,
	input  logic [$clog2(DEPTH+1)-1:0]   cnt_in,
	input  logic                         dup_in,
	output logic [$clog2(DEPTH+1)-1:0]   cnt_out,
	output logic                         dup_out
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [ID_BITS-1:0]    src_q;
	logic [ID_BITS-1:0]    dst_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  dup_q;
	logic                  live;
	logic                  dup_hit;
	logic                  cnt_hit;

	assign live    = CNT_W'(IDX) < occ;
	assign dup_hit = live && (src_q == req_src) && (dst_q == req_dst) && (stamp_q == req_stamp);
	assign cnt_hit = live && (dst_q == req_dst) && (stamp_q >= req_lo) && (stamp_q <= req_hi);

	// write of a new packet wins over the shift toward the head
	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (wr_idx == IDX_W'(IDX))) begin
			src_q   <= req_src;
			dst_q   <= req_dst;
			stamp_q <= req_stamp;
		end else if (ctrl.shift) begin
			src_q   <= nxt_src;
			dst_q   <= nxt_dst;
			stamp_q <= nxt_stamp;
		end
		cnt_q <= cnt_in + CNT_W'(cnt_hit);
		dup_q <= dup_in | dup_hit;
	end

	assign src     = src_q;
	assign dst     = dst_q;
	assign stamp   = stamp_q;
	assign cnt_out = cnt_q;
	assign dup_out = dup_q;

endmodule

// File: bench/pfdc_checker.sv
`timescale 1ns / 100ps
// result checker for the packet fifo with duplicate filter and range count
module pfdc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [1:0]                      func,
	input  logic [15:0]                     src_id,
	input  logic [15:0]                     dst_id,
	input  logic [31:0]                     stamp,
	input  logic [31:0]                     start_time,
	input  logic [31:0]                     end_time,
	input  logic                            done,
	input  logic                            ok,
	input  logic [15:0]                     out_src,
	input  logic [15:0]                     out_dst,
	input  logic [31:0]                     out_stamp,
	input  logic [pfdc_pkg::COUNT_BITS-1:0] match_count,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [pfdc_pkg::LIMIT_BITS-1:0] cfg_data,
	output int                              outstanding,
	output int                              fail_count,
	output int                              beats_checked
);
	localparam int CAPACITY = 64;

	typedef struct packed {
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] stamp;
	} packet_t;

	typedef struct packed {
		logic                            ok;
		logic [15:0]                     src;
		logic [15:0]                     dst;
		logic [31:0]                     stamp;
		logic [pfdc_pkg::COUNT_BITS-1:0] hits;
	} reply_t;

	packet_t                         held[$];
	reply_t                          pending_q[$];
	logic [pfdc_pkg::LIMIT_BITS-1:0] limit_reg;

	task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
		fail_count++;
		if (fail_count <= 50)
			$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// updates the held packets and returns the reply the block owes
	function automatic reply_t apply_packet_op(logic [1:0] code, packet_t pkt,
			logic [31:0] lo, logic [31:0] hi);
		reply_t          r;
		packet_t         p;
		pfdc_pkg::func_t op;
		int              cap;
		int              n;
		bit              dup;
		r = '0;
		op = pfdc_pkg::func_t'(code);
		cap = (limit_reg == 0) ? 1 : (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
		case (op)
			pfdc_pkg::FUNC_ADD: begin
				dup = 0;
				foreach (held[i])
					if (held[i] == pkt)
						dup = 1;
				if (!dup) begin
					// only the single oldest goes, even if the limit was lowered
					if (held.size() >= cap)
						void'(held.pop_front());
					held.insert(held.size(), pkt);
					r.ok = 1'b1;
				end
			end
			pfdc_pkg::FUNC_FWD: begin
				if (held.size() > 0) begin
					p = held.pop_front();
					r.ok = 1'b1;
					r.src = p.src;
					r.dst = p.dst;
					r.stamp = p.stamp;
				end
			end
			pfdc_pkg::FUNC_COUNT: begin
				n = 0;
				foreach (held[i])
					if (held[i].dst == pkt.dst && held[i].stamp >= lo && held[i].stamp <= hi)
						n++;
				r.hits = (n > int'(pfdc_pkg::COUNT_MAX)) ? pfdc_pkg::COUNT_MAX :
					n[pfdc_pkg::COUNT_BITS-1:0];
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			held.delete();
			pending_q.delete();
			limit_reg = pfdc_pkg::LIMIT_RESET;
			outstanding <= 0;
			fail_count = 0;
			beats_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_reg = cfg_data;
			// a finishing beat belongs to the older op, so check before queuing
			if (done) begin
				if (pending_q.size() == 0) begin
					flag_mismatch("result beat with nothing pending", 1, 0);
				end else begin
					want = pending_q.pop_front();
					beats_checked++;
					if (ok !== want.ok)
						flag_mismatch("ok", ok, want.ok);
					if (out_src !== want.src)
						flag_mismatch("out_src", out_src, want.src);
					if (out_dst !== want.dst)
						flag_mismatch("out_dst", out_dst, want.dst);
					if (out_stamp !== want.stamp)
						flag_mismatch("out_stamp", out_stamp, want.stamp);
					if (match_count !== want.hits)
						flag_mismatch("match_count", match_count, want.hits);
				end
			end
			if (start && !busy)
				pending_q.insert(pending_q.size(), apply_packet_op(func,
					'{src_id, dst_id, stamp}, start_time, end_time));
			outstanding <= pending_q.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// top of the bench: stimulus, clock, reset and verdict for the packet fifo
module tb;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	pfdc_pkg::func_t                 func = pfdc_pkg::FUNC_NONE;
	logic [15:0]                     src_id = '0;
	logic [15:0]                     dst_id = '0;
	logic [31:0]                     stamp = '0;
	logic [31:0]                     start_time = '0;
	logic [31:0]                     end_time = '0;
	logic                            done;
	logic                            ok;
	logic [15:0]                     out_src;
	logic [15:0]                     out_dst;
	logic [31:0]                     out_stamp;
	logic [pfdc_pkg::COUNT_BITS-1:0] match_count;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [pfdc_pkg::LIMIT_BITS-1:0] cfg_data = '0;

	int outstanding;
	int fail_count;
	int beats_checked;

	// sender idle chance in percent per cycle, changed per phase
	int idle_pct = 30;
	int op_tally[4];
	int limit_writes = 0;

	// small pools so duplicates and count hits show up often
	logic [15:0] src_pool[3];
	logic [15:0] dst_pool[3];
	logic [31:0] stamp_base;

	// memory_limit settings walked by the random part: over-range, reset value,
	// lowered well below occupancy, 0, 1, 2, 40, just over the depth and 64
	logic [pfdc_pkg::LIMIT_BITS-1:0] limit_plan[9] = '{7'd127, 7'd64, 7'd5, 7'd0, 7'd1,
		7'd2, 7'd40, 7'd65, 7'd64};

	packet_fifo_dedup_count dut (.*);
	pfdc_checker checker_i (.*);

	always #4 clk = ~clk;

	// hands one operation beat to the block, with an optional gap before it;
	// start is left high on return so a back-to-back beat needs no toggle
	task automatic send_op(pfdc_pkg::func_t op, logic [15:0] s, logic [15:0] d,
			logic [31:0] st, logic [31:0] lo, logic [31:0] hi);
		int n;
		n = 0;
		while (n < 24 && $urandom_range(0, 99) < idle_pct)
			n++;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		start <= 1'b1;
		func <= op;
		src_id <= s;
		dst_id <= d;
		stamp <= st;
		start_time <= lo;
		end_time <= hi;
		// busy read here is its value at the edge, so this is the accepting edge
		do @(posedge clk); while (busy);
		op_tally[op]++;
	endtask

	// drop start and wait until every owed result beat is back
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		// every op returns a beat, so the wait that follows is only a margin
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [pfdc_pkg::LIMIT_BITS-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_writes++;
	endtask

	// one random op, mostly drawn from the pools, sometimes fully random
	task automatic random_op(int add_pct);
		int          roll;
		logic [15:0] s;
		logic [15:0] d;
		logic [31:0] st;
		logic [31:0] lo;
		logic [31:0] hi;
		roll = $urandom_range(0, 99);
		s = src_pool[$urandom_range(0, 2)];
		d = dst_pool[$urandom_range(0, 2)];
		st = stamp_base + $urandom_range(0, 7);
		lo = stamp_base + $urandom_range(0, 9);
		hi = lo + $urandom_range(0, 6);
		if ($urandom_range(0, 5) == 0) begin
			s = 16'($urandom);
			d = 16'($urandom);
			st = $urandom;
		end
		case ($urandom_range(0, 7))
			0: begin
				// reversed bounds, usually an empty range
				lo = hi;
				hi = stamp_base + $urandom_range(0, 3);
			end
			1: begin
				lo = $urandom;
				hi = $urandom;
			end
			2: begin
				lo = '0;
				hi = '1;
			end
			default: ;
		endcase
		if (roll >= 97)
			send_op(pfdc_pkg::FUNC_NONE, 16'($urandom), 16'($urandom), $urandom,
				$urandom, $urandom);
		else if (roll < add_pct)
			send_op(pfdc_pkg::FUNC_ADD, s, d, st, lo, hi);
		else if (roll < add_pct + (97 - add_pct) * 2 / 5)
			send_op(pfdc_pkg::FUNC_FWD, s, d, st, lo, hi);
		else
			send_op(pfdc_pkg::FUNC_COUNT, s, d, st, lo, hi);
	endtask

	initial begin
		// async reset held from the start, released on a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty fifo, unused code, field extremes, duplicates, ranges
		send_op(pfdc_pkg::FUNC_FWD, '0, '0, '0, '0, '0);
		send_op(pfdc_pkg::FUNC_COUNT, '0, '0, '0, '0, '1);
		send_op(pfdc_pkg::FUNC_NONE, '1, '1, '1, '1, '1);
		send_op(pfdc_pkg::FUNC_ADD, '0, '0, '0, '0, '0);
		send_op(pfdc_pkg::FUNC_ADD, '1, '1, '1, '0, '0);
		send_op(pfdc_pkg::FUNC_ADD, '0, '0, '0, '1, '1);
		send_op(pfdc_pkg::FUNC_ADD, '0, '0, 32'd1, '0, '0);
		send_op(pfdc_pkg::FUNC_ADD, '1, '0, '0, '0, '0);
		send_op(pfdc_pkg::FUNC_ADD, '1, '1, '1, '0, '0);
		send_op(pfdc_pkg::FUNC_COUNT, '1, '0, '1, '0, '1);
		send_op(pfdc_pkg::FUNC_COUNT, '0, '0, '0, 32'd1, '0);
		send_op(pfdc_pkg::FUNC_COUNT, '0, '0, '0, 32'd1, 32'd1);
		send_op(pfdc_pkg::FUNC_COUNT, '0, '1, '0, '1, '1);
		// timestamp going backwards is legal here
		send_op(pfdc_pkg::FUNC_ADD, 16'h5a5a, 16'ha5a5, 32'h0000_0005, '0, '0);
		send_op(pfdc_pkg::FUNC_NONE, '0, '0, '0, '0, '0);
		repeat (6)
			send_op(pfdc_pkg::FUNC_FWD, '1, '1, '1, '1, '1);
		send_op(pfdc_pkg::FUNC_COUNT, '0, '0, '0, '0, '1);

		// random phases, one memory_limit setting each; the fifo is not drained
		// between phases, so lowering the limit leaves it over-full
		foreach (limit_plan[p]) begin
			idle_pct = (p < 3) ? 30 : (p < 6) ? 66 : 0;
			write_limit(limit_plan[p]);
			foreach (src_pool[i]) begin
				src_pool[i] = 16'($urandom);
				dst_pool[i] = 16'($urandom);
			end
			stamp_base = $urandom;
			repeat (158)
				random_op((limit_plan[p] >= 40) ? 72 : 50);
		end

		settle();
		$display("ran %0d ops: %0d add, %0d forward, %0d count, %0d unused code",
			op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
			op_tally[pfdc_pkg::FUNC_ADD], op_tally[pfdc_pkg::FUNC_FWD],
			op_tally[pfdc_pkg::FUNC_COUNT], op_tally[pfdc_pkg::FUNC_NONE]);
		$display("%0d result beats compared over %0d memory_limit writes",
			beats_checked, limit_writes);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5000000;
		$display("timeout with %0d result beats still owed", outstanding);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/pfdc_pkg.sv
hw/rtl/pfdc_cell.sv
hw/rtl/packet_fifo_dedup_count.sv
bench/pfdc_checker.sv
bench/tb.sv
